// ===== design/r2b_pkg.sv =====
// ----------------------------------------------------------------------------
// r2b_pkg
// Shared types, constants and the BMP header byte decoder for the RGB565 to
// 24-bit BMP byte stream converter.
// ----------------------------------------------------------------------------
package r2b_pkg;

    localparam int PIXEL_W         = 16;
    localparam int SIZE_W          = 32;
    localparam int DIM_W           = 16;
    localparam int POS_W           = 6;

    localparam int HDR_BYTES       = 54;
    localparam int INFO_BYTES      = 40;
    localparam int BITS_PER_PIXEL  = 24;

    localparam int WIDTH_RESET     = 320;
    localparam int HEIGHT_RESET    = 240;
    localparam int TOTAL_RESET     = WIDTH_RESET * HEIGHT_RESET;
    localparam int IMG_RESET       = 3 * TOTAL_RESET;
    localparam int FILE_RESET      = HDR_BYTES + IMG_RESET;

    localparam int QUEUE_DEPTH_DEF = 2;

    // Byte positions inside the word sequence of one pixel.
    localparam logic [POS_W-1:0] POS_FIRST_HDR = POS_W'(0);
    localparam logic [POS_W-1:0] POS_B         = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] POS_G         = POS_W'(HDR_BYTES + 1);
    localparam logic [POS_W-1:0] POS_R         = POS_W'(HDR_BYTES + 2);

    // Configuration register indexes.
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // Cycles after a configuration write until the derived sizes are settled.
    localparam logic [1:0] CFG_SETTLE = 2'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               hdr;
        logic               eof;
    } pix_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [SIZE_W-1:0] neg_height;
        logic [SIZE_W-1:0] raster_len;
        logic [SIZE_W-1:0] bmp_len;
    } hdr_info_t;

    function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] idx,
                                            input hdr_info_t info);
        logic [7:0] b;
        b = 8'h00;
        unique case (idx) inside
            6'd0:  b = 8'h42;
            6'd1:  b = 8'h4D;
            6'd2:  b = info.bmp_len[7:0];
            6'd3:  b = info.bmp_len[15:8];
            6'd4:  b = info.bmp_len[23:16];
            6'd5:  b = info.bmp_len[31:24];
            [6'd6:6'd9], [6'd11:6'd13], [6'd15:6'd17], [6'd20:6'd21],
            6'd27, [6'd29:6'd33], [6'd38:6'd53]:
                b = 8'h00;
            6'd10: b = 8'(HDR_BYTES);
            6'd14: b = 8'(INFO_BYTES);
            6'd18: b = info.width[7:0];
            6'd19: b = info.width[15:8];
            6'd22: b = info.neg_height[7:0];
            6'd23: b = info.neg_height[15:8];
            6'd24: b = info.neg_height[23:16];
            6'd25: b = info.neg_height[31:24];
            6'd26: b = 8'h01;
            6'd28: b = 8'(BITS_PER_PIXEL);
            6'd34: b = info.raster_len[7:0];
            6'd35: b = info.raster_len[15:8];
            6'd36: b = info.raster_len[23:16];
            6'd37: b = info.raster_len[31:24];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== design/r2b_cfg.sv =====
// ----------------------------------------------------------------------------
// r2b_cfg
// Configuration registers and the short pipeline that derives pixel total,
// image size, file size and negated height from them.
// ----------------------------------------------------------------------------
module r2b_cfg
    import r2b_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic              cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    output logic [SIZE_W-1:0] total,
    output hdr_info_t         info,
    output logic              busy
);

    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [SIZE_W-1:0] total_reg, total_next;
    logic [SIZE_W-1:0] img_reg, img_next;
    logic [SIZE_W-1:0] neg_h_reg, neg_h_next;
    logic [SIZE_W-1:0] file_reg, file_next;
    logic [1:0]        settle_reg, settle_next;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  width_next  = cfg_data;
                CFG_IDX_HEIGHT: height_next = cfg_data;
                default:        width_next  = width_reg;
            endcase
        end
    end

    assign total_next = {{(SIZE_W-DIM_W){1'b0}}, width_reg}
                      * {{(SIZE_W-DIM_W){1'b0}}, height_reg};
    assign img_next   = total_reg + {total_reg[SIZE_W-2:0], 1'b0};
    assign neg_h_next = SIZE_W'(0) - {{(SIZE_W-DIM_W){1'b0}}, height_reg};
    assign file_next  = img_reg + SIZE_W'(HDR_BYTES);

    always_comb
    begin
        if (cfg_wen)
            settle_next = CFG_SETTLE;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(WIDTH_RESET);
            height_reg <= DIM_W'(HEIGHT_RESET);
            total_reg  <= SIZE_W'(TOTAL_RESET);
            img_reg    <= SIZE_W'(IMG_RESET);
            neg_h_reg  <= SIZE_W'(0) - SIZE_W'(HEIGHT_RESET);
            file_reg   <= SIZE_W'(FILE_RESET);
            settle_reg <= 2'd0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            total_reg  <= total_next;
            img_reg    <= img_next;
            neg_h_reg  <= neg_h_next;
            file_reg   <= file_next;
            settle_reg <= settle_next;
        end
    end

    assign total           = total_reg;
    assign info.width      = width_reg;
    assign info.neg_height = neg_h_reg;
    assign info.raster_len = img_reg;
    assign info.bmp_len    = file_reg;
    assign busy            = (settle_reg != 2'd0);

endmodule

// ===== design/r2b_front.sv =====
// ----------------------------------------------------------------------------
// r2b_front
// Input side: accepts pixels, keeps the frame pixel count and tags each pixel
// with whether it opens a frame (header needed) and whether it closes one.
// ----------------------------------------------------------------------------
module r2b_front
    import r2b_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIXEL_W-1:0] pixel_rgb565,
    input  logic [SIZE_W-1:0]  total,
    input  logic               cfg_busy,
    input  logic               q_full,
    output logic               q_push,
    output pix_item_t          q_item
);

    logic [SIZE_W-1:0] count_reg, count_next;
    logic [SIZE_W-1:0] count_inc;
    logic              last_px;

    assign in_stall  = q_full | cfg_busy;
    assign q_push    = in_valid & ~in_stall;

    assign count_inc = count_reg + SIZE_W'(1);
    // A count at or past the total ends the frame, which also covers a size
    // that shrank in the middle of a frame and a size of zero.
    assign last_px   = (count_inc >= total);

    assign q_item.pixel = pixel_rgb565;
    assign q_item.hdr   = (count_reg == SIZE_W'(0));
    assign q_item.eof   = last_px;

    always_comb
    begin
        count_next = count_reg;
        if (q_push)
            count_next = last_px ? SIZE_W'(0) : count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= SIZE_W'(0);
        else
            count_reg <= count_next;
    end

endmodule

// ===== design/r2b_queue.sv =====
// ----------------------------------------------------------------------------
// r2b_queue
// Small register FIFO of tagged pixels between the input side and the byte
// sequencer.
// ----------------------------------------------------------------------------
module r2b_queue
    import r2b_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pix_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output pix_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != CNT_W'(0));
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

endmodule

// ===== design/r2b_back.sv =====
// ----------------------------------------------------------------------------
// r2b_back
// Byte sequencer: walks the header bytes when a pixel opens a frame, then the
// B, G and R bytes, one word per cycle into an output register while out_stall is low.
// ----------------------------------------------------------------------------
module r2b_back
    import r2b_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  pix_item_t q_item,
    output logic      q_pop,
    input  hdr_info_t info,
    output logic      out_valid,
    input  logic      out_stall,
    output logic [7:0] out_byte,
    output logic      last_of_item,
    output logic      end_of_file
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             started_reg, started_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             eof_reg, eof_next;
    logic [POS_W-1:0] cur_pos;
    logic             load;
    logic [4:0]       red5, blue5;
    logic [5:0]       green6;

    // A fresh item starts at the first header byte or directly at its B byte.
    assign cur_pos = started_reg ? pos_reg : (q_item.hdr ? POS_FIRST_HDR : POS_B);
    assign load    = q_valid & (~valid_reg | ~out_stall);
    assign q_pop   = load & (cur_pos == POS_R);

    assign red5   = q_item.pixel[15:11];
    assign green6 = q_item.pixel[10:5];
    assign blue5  = q_item.pixel[4:0];

    always_comb
    begin
        if (cur_pos == POS_B)
            byte_next = {blue5, blue5[4:2]};
        else if (cur_pos == POS_G)
            byte_next = {green6, green6[5:4]};
        else if (cur_pos == POS_R)
            byte_next = {red5, red5[4:2]};
        else
            byte_next = hdr_byte(cur_pos, info);
    end

    assign last_next = (cur_pos == POS_R);
    assign eof_next  = (cur_pos == POS_R) & q_item.eof;

    always_comb
    begin
        pos_next     = pos_reg;
        started_next = started_reg;
        if (load)
        begin
            if (cur_pos == POS_R)
            begin
                started_next = 1'b0;
            end
            else
            begin
                pos_next     = cur_pos + 1'b1;
                started_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_FIRST_HDR;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            eof_reg  <= eof_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign last_of_item = last_reg;
    assign end_of_file  = eof_reg;

    // The head item must stay in the queue until its R byte has been issued.
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> q_valid)
        else $error("item in progress left the queue");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> (pos_reg <= POS_R) && (pos_reg != POS_FIRST_HDR))
        else $error("byte position out of range");

    a_eof_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && eof_reg) |-> last_reg)
        else $error("end of file flagged on a word that does not close a pixel");

endmodule

// ===== design/rgb565_to_bmp24_stream_top.sv =====
// A pixel accepted at the input passes the queue and then the output byte register
// before its first word shows. Throughput: one word per cycle while out_stall is low
// and the queue holds a pixel; a pixel gives 3 words, and 57 when it opens a frame as
// the 54-byte header goes first through the same byte sequencer. A configuration write
// stalls the input while the multiplier for the frame size and the size adders settle.
// Reset sets 320 x 240 and clears the pixel count and the queue; no clearing pass.
// ----------------------------------------------------------------------------
// rgb565_to_bmp24_stream_top
// Converts a stream of RGB565 pixels into the byte stream of a top-down
// 24-bit BMP file, with a header in front of every frame.
// ----------------------------------------------------------------------------
module rgb565_to_bmp24_stream_top
    import r2b_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIXEL_W-1:0] pixel_rgb565,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               last_of_item,
    output logic               end_of_file,
    input  logic               cfg_wen,
    input  logic               cfg_index,
    input  logic [DIM_W-1:0]   cfg_data
);

    logic [SIZE_W-1:0] total;
    hdr_info_t         info;
    logic              cfg_busy;
    logic              q_full;
    logic              q_push;
    pix_item_t         q_in_item;
    logic              q_pop;
    logic              q_valid;
    pix_item_t         q_head;

    r2b_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .total     (total),
        .info      (info),
        .busy      (cfg_busy)
    );

    r2b_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_rgb565 (pixel_rgb565),
        .total        (total),
        .cfg_busy     (cfg_busy),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_in_item)
    );

    r2b_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    r2b_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_head),
        .q_pop        (q_pop),
        .info         (info),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_file  (end_of_file)
    );

endmodule
